/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is active
`define BQSM_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("bqsm assertion failed");

// Clocked assertion that also holds while reset is active
`define BQSM_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("bqsm assertion failed");

`endif

/* hw/rtl/bqsm_pkg.sv */
// Shared constants, register codes and the line event struct of the queue monitor.
// No dependencies.
package bqsm_pkg;

  // Line store geometry
  localparam int QueueDepth = 64;
  localparam int StampWidth = 32;
  localparam int PtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int OccW       = $clog2(QueueDepth + 1);

  // Register and field widths
  localparam int BusyW    = 16;
  localparam int LimitW   = 7;
  localparam int CfgDataW = 16;
  localparam int CfgIdxW  = 1;
  localparam int ServedW  = 32;
  localparam int WaitW    = 48;
  localparam int LengthW  = 48;
  localparam int DropW    = 32;
  localparam int LineW    = 7;
  localparam int WaitSumW = ((StampWidth > WaitW) ? StampWidth : WaitW) + 1;

  // Register reset values
  localparam logic [BusyW-1:0]  ServiceTicksReset = 16'd1;
  localparam logic [LimitW-1:0] LineLimitReset    = 7'd64;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgServiceTicks = 1'b0,
    CfgLineLimit    = 1'b1
  } cfg_idx_e;

  // What one tick did to the line
  typedef struct packed {
    logic                  pop;
    logic                  drop;
    logic                  fwd;
    logic [OccW-1:0]       occ_start;
    logic [OccW-1:0]       occ_now;
    logic [StampWidth-1:0] tick;
  } line_evt_t;

endpackage

/* hw/rtl/bounded_queue_service_monitor_unit.sv */
// Top level of the single-server bounded queue monitor: handshake, registers, totals.
// Depends on bqsm_pkg and bqsm_line.
//
// Usage:
//   Each input item is one tick carrying arrived_i, taken when in_valid_i and
//   in_ready_o are high. Each item gives exactly one result item on the
//   output channel (out_valid_o/out_ready_i) with the saturating totals
//   served, waited, line length and dropped, and the line length after the
//   tick.
//   Throughput: one item per cycle while out_ready_i keeps the result moving;
//   the line step runs in the accept cycle and the stamp memory is read there,
//   and the wait is summed in the middle stage before the output register.
//   A stalled receiver holds the result; one more item may enter and wait
//   in the middle stage, after which in_ready_o drops.
//   Reset clears all totals, the line and the tick count; service_ticks returns to 1
//   and line_limit to 64. The stamp memory is not cleared. The user must write
//   registers (cfg_we_i, cfg_idx_i, cfg_wdata_i) while idle, unchecked by the block.
module bounded_queue_service_monitor_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          arrived_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bqsm_pkg::ServedW-1:0]  served_total_o,
  output logic [bqsm_pkg::WaitW-1:0]    wait_total_o,
  output logic [bqsm_pkg::LengthW-1:0]  length_total_o,
  output logic [bqsm_pkg::DropW-1:0]    dropped_total_o,
  output logic [bqsm_pkg::LineW-1:0]    line_now_o,
  input  logic                          cfg_we_i,
  input  logic [bqsm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bqsm_pkg::CfgDataW-1:0] cfg_wdata_i
);

  logic [bqsm_pkg::BusyW-1:0]      service_ticks_q;
  logic [bqsm_pkg::LimitW-1:0]     line_limit_q;
  logic                            step, s1_move;
  logic                            s1_valid_q, out_valid_q;
  bqsm_pkg::line_evt_t             evt, s1_evt_q;
  logic [bqsm_pkg::StampWidth-1:0] stamp, stamp_eff, waited;
  logic [bqsm_pkg::WaitSumW-1:0]   wait_sum;
  logic [bqsm_pkg::LengthW:0]      length_sum;
  logic [bqsm_pkg::ServedW-1:0]    served_q, served_d;
  logic [bqsm_pkg::WaitW-1:0]      wait_q, wait_d;
  logic [bqsm_pkg::LengthW-1:0]    length_q, length_d;
  logic [bqsm_pkg::DropW-1:0]      dropped_q, dropped_d;
  logic [bqsm_pkg::LineW-1:0]      line_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      service_ticks_q <= bqsm_pkg::ServiceTicksReset;
      line_limit_q    <= bqsm_pkg::LineLimitReset;
    end else if (cfg_we_i) begin
      unique case (bqsm_pkg::cfg_idx_e'(cfg_idx_i))
        bqsm_pkg::CfgServiceTicks: service_ticks_q <= cfg_wdata_i[bqsm_pkg::BusyW-1:0];
        bqsm_pkg::CfgLineLimit:    line_limit_q    <= cfg_wdata_i[bqsm_pkg::LimitW-1:0];
      endcase
    end
  end

  // Handshake: middle stage moves when the output register is free or being read
  assign s1_move    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_move;
  assign step       = in_valid_i && in_ready_o;

  bqsm_line u_line (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .arrived_i      (arrived_i),
    .service_ticks_i(service_ticks_q),
    .line_limit_i   (line_limit_q),
    .evt_o          (evt),
    .stamp_o        (stamp)
  );

  // Hold the tick event for the summing stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      s1_evt_q <= evt;
    end
  end

  // Update saturating totals
  always_comb begin
    stamp_eff  = s1_evt_q.fwd ? s1_evt_q.tick : stamp;
    waited     = s1_evt_q.pop ? s1_evt_q.tick - stamp_eff : '0;
    wait_sum   = bqsm_pkg::WaitSumW'(wait_q) + bqsm_pkg::WaitSumW'(waited);
    wait_d     = (wait_sum[bqsm_pkg::WaitSumW-1:bqsm_pkg::WaitW] != '0) ? '1
               : wait_sum[bqsm_pkg::WaitW-1:0];
    length_sum = {1'b0, length_q} + (bqsm_pkg::LengthW + 1)'(s1_evt_q.occ_start);
    length_d   = length_sum[bqsm_pkg::LengthW] ? '1 : length_sum[bqsm_pkg::LengthW-1:0];
    served_d   = (s1_evt_q.pop && (served_q != '1)) ? served_q + 1'b1 : served_q;
    dropped_d  = (s1_evt_q.drop && (dropped_q != '1)) ? dropped_q + 1'b1 : dropped_q;
  end

  // Output register doubles as the accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      served_q    <= '0;
      wait_q      <= '0;
      length_q    <= '0;
      dropped_q   <= '0;
      line_q      <= '0;
    end else begin
      if (s1_move) begin
        out_valid_q <= 1'b1;
        served_q    <= served_d;
        wait_q      <= wait_d;
        length_q    <= length_d;
        dropped_q   <= dropped_d;
        line_q      <= bqsm_pkg::LineW'(s1_evt_q.occ_now);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign served_total_o  = served_q;
  assign wait_total_o    = wait_q;
  assign length_total_o  = length_q;
  assign dropped_total_o = dropped_q;
  assign line_now_o      = line_q;

endmodule

/* hw/rtl/bqsm_line.sv */
// Line control of the queue monitor: stamp memory, pointers, occupancy, service countdown.
// Depends on bqsm_pkg.
module bqsm_line (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic                           arrived_i,
  input  logic [bqsm_pkg::BusyW-1:0]     service_ticks_i,
  input  logic [bqsm_pkg::LimitW-1:0]    line_limit_i,
  output bqsm_pkg::line_evt_t            evt_o,
  output logic [bqsm_pkg::StampWidth-1:0] stamp_o
);

  // Stamp memory, one write and one read port
  logic [bqsm_pkg::StampWidth-1:0] stamp_mem [bqsm_pkg::QueueDepth];
  logic [bqsm_pkg::StampWidth-1:0] stamp_q;

  logic [bqsm_pkg::StampWidth-1:0] tick_q, tick_d;
  logic [bqsm_pkg::PtrW-1:0]       head_q, head_d, tail_q, tail_d;
  logic [bqsm_pkg::OccW-1:0]       occ_q, occ_d, occ_mid, limit_eff;
  logic [bqsm_pkg::BusyW-1:0]      busy_q, busy_d, busy_dec;
  logic                            push, drop, pop, fwd;

  // Clamp the limit to the store depth
  always_comb begin
    if (32'(line_limit_i) > 32'(bqsm_pkg::QueueDepth)) begin
      limit_eff = bqsm_pkg::OccW'(bqsm_pkg::QueueDepth);
    end else begin
      limit_eff = bqsm_pkg::OccW'(line_limit_i);
    end
  end

  // Decide push, drop and pop for this tick
  always_comb begin
    push     = arrived_i && (occ_q < limit_eff);
    drop     = arrived_i && !push;
    occ_mid  = occ_q + bqsm_pkg::OccW'(push);
    busy_dec = (busy_q != '0) ? busy_q - 1'b1 : busy_q;
    pop      = (busy_dec == '0) && (occ_mid != '0);
    // Entry written and taken in the same tick: memory read is stale
    fwd      = pop && (occ_q == '0);
    occ_d    = occ_mid - bqsm_pkg::OccW'(pop);
    busy_d   = pop ? service_ticks_i : busy_dec;
    tick_d   = tick_q + 1'b1;
    if (push) begin
      tail_d = (tail_q == bqsm_pkg::PtrW'(bqsm_pkg::QueueDepth - 1)) ? '0 : tail_q + 1'b1;
    end else begin
      tail_d = tail_q;
    end
    if (pop) begin
      head_d = (head_q == bqsm_pkg::PtrW'(bqsm_pkg::QueueDepth - 1)) ? '0 : head_q + 1'b1;
    end else begin
      head_d = head_q;
    end
  end

  // Advance control state once per accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      head_q <= '0;
      tail_q <= '0;
      occ_q  <= '0;
      busy_q <= '0;
    end else if (step_i) begin
      tick_q <= tick_d;
      head_q <= head_d;
      tail_q <= tail_d;
      occ_q  <= occ_d;
      busy_q <= busy_d;
    end
  end

  // Write the arrival stamp, read the head entry
  always_ff @(posedge clk_i) begin
    if (step_i && push) begin
      stamp_mem[tail_q] <= tick_q;
    end
    if (step_i) begin
      stamp_q <= stamp_mem[head_q];
    end
  end

  assign evt_o.pop       = pop;
  assign evt_o.drop      = drop;
  assign evt_o.fwd       = fwd;
  assign evt_o.occ_start = occ_q;
  assign evt_o.occ_now   = occ_d;
  assign evt_o.tick      = tick_q;
  assign stamp_o         = stamp_q;

endmodule

/* hw/rtl/bqsm_checker.sv */
// Port-level checks of the queue monitor, bound to the top level.
// Depends on bqsm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bqsm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [bqsm_pkg::ServedW-1:0]  served_total_o,
  input logic [bqsm_pkg::WaitW-1:0]    wait_total_o,
  input logic [bqsm_pkg::LineW-1:0]    line_now_o
);

  // No result while reset is held
  `BQSM_ASSERT_ALWAYS(a_no_out_in_reset, clk_i, !rst_ni |-> !out_valid_o)

  // Input stalls only behind a held result
  `BQSM_ASSERT(a_stall_cause, clk_i, rst_ni, !in_ready_o |-> (out_valid_o && !out_ready_i))

  // Stalled result holds
  `BQSM_ASSERT(a_out_hold, clk_i, rst_ni,
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(served_total_o)))

  // Served and wait totals never fall
  `BQSM_ASSERT(a_totals_rise, clk_i, rst_ni,
    1'b1 |=> ((served_total_o >= $past(served_total_o)) && (wait_total_o >= $past(wait_total_o))))

  // Line never exceeds the store
  `BQSM_ASSERT(a_line_bound, clk_i, rst_ni,
    out_valid_o |-> (32'(line_now_o) <= 32'(bqsm_pkg::QueueDepth)))

endmodule

bind bounded_queue_service_monitor_unit bqsm_checker u_bqsm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .served_total_o(served_total_o),
  .wait_total_o  (wait_total_o),
  .line_now_o    (line_now_o)
);

/* verif/bounded_queue_service_monitor_unit_tb.sv */
// Self-checking testbench for the bounded queue service monitor: a table of directed ticks,
// then random ticks under a series of register settings, checked against a local line model.
// Depends on bqsm_pkg and the RTL top level bounded_queue_service_monitor_unit.
module bounded_queue_service_monitor_unit_tb;
  import bqsm_pkg::*;

  localparam int          WatchdogLimit = 1000;
  localparam int          PhaseCount    = 10;
  localparam int          PhaseTicks    = 183;
  localparam logic [63:0] Top32         = 64'hFFFF_FFFF;
  localparam logic [63:0] Top48         = 64'hFFFF_FFFF_FFFF;

  // Totals carried by one result item
  typedef struct packed {
    logic [ServedW-1:0] served;
    logic [WaitW-1:0]   waited;
    logic [LengthW-1:0] length;
    logic [DropW-1:0]   dropped;
    logic [LineW-1:0]   line;
  } totals_t;

  // One directed row: a register write, or a tick with an optional typed-in result
  typedef struct packed {
    logic                is_cfg;
    cfg_idx_e            idx;
    logic [CfgDataW-1:0] data;
    logic                arrived;
    logic                lit;
    totals_t             want;
  } row_t;

  localparam int DirRows = 24;
  localparam row_t DirTable [DirRows] = '{
    // idle tick straight after reset, then two customers served on arrival
    '{1'b0, CfgServiceTicks, 16'd0, 1'b0, 1'b1, '{32'd0, 48'd0, 48'd0, 32'd0, 7'd0}},
    '{1'b0, CfgServiceTicks, 16'd0, 1'b1, 1'b1, '{32'd1, 48'd0, 48'd0, 32'd0, 7'd0}},
    '{1'b0, CfgServiceTicks, 16'd0, 1'b1, 1'b1, '{32'd2, 48'd0, 48'd0, 32'd0, 7'd0}},
    // zero limit turns every arrival away
    '{1'b1, CfgLineLimit,    16'd0, 1'b0, 1'b0, '0},
    '{1'b0, CfgServiceTicks, 16'd0, 1'b1, 1'b1, '{32'd2, 48'd0, 48'd0, 32'd1, 7'd0}},
    // slow server, limit above the store capacity
    '{1'b1, CfgServiceTicks, 16'd5, 1'b0, 1'b0, '0},
    '{1'b1, CfgLineLimit,  16'd127, 1'b0, 1'b0, '0},
    '{1'b0, CfgServiceTicks, 16'd0, 1'b1, 1'b0, '0},
    '{1'b0, CfgServiceTicks, 16'd0, 1'b1, 1'b0, '0},
    '{1'b0, CfgServiceTicks, 16'd0, 1'b1, 1'b0, '0},
    '{1'b0, CfgServiceTicks, 16'd0, 1'b1, 1'b0, '0},
    '{1'b0, CfgServiceTicks, 16'd0, 1'b1, 1'b0, '0},
    '{1'b0, CfgServiceTicks, 16'd0, 1'b1, 1'b0, '0},
    // limit dropped below the waiting count
    '{1'b1, CfgLineLimit,    16'd2, 1'b0, 1'b0, '0},
    '{1'b0, CfgServiceTicks, 16'd0, 1'b1, 1'b0, '0},
    '{1'b0, CfgServiceTicks, 16'd0, 1'b1, 1'b0, '0},
    '{1'b0, CfgServiceTicks, 16'd0, 1'b0, 1'b0, '0},
    // zero service time: one customer taken per tick
    '{1'b1, CfgServiceTicks, 16'd0, 1'b0, 1'b0, '0},
    '{1'b0, CfgServiceTicks, 16'd0, 1'b1, 1'b0, '0},
    '{1'b0, CfgServiceTicks, 16'd0, 1'b0, 1'b0, '0},
    '{1'b0, CfgServiceTicks, 16'd0, 1'b1, 1'b0, '0},
    '{1'b0, CfgServiceTicks, 16'd0, 1'b1, 1'b0, '0},
    '{1'b0, CfgServiceTicks, 16'd0, 1'b0, 1'b0, '0},
    '{1'b0, CfgServiceTicks, 16'd0, 1'b0, 1'b0, '0}
  };

  logic                clk_i;
  logic                rst_ni    = 1'b1;
  logic                in_valid  = 1'b0;
  logic                arrived   = 1'b0;
  logic                out_ready = 1'b0;
  logic                cfg_we    = 1'b0;
  cfg_idx_e            cfg_idx   = CfgServiceTicks;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_ready_o;
  logic                out_valid_o;
  logic [ServedW-1:0]  served_total_o;
  logic [WaitW-1:0]    wait_total_o;
  logic [LengthW-1:0]  length_total_o;
  logic [DropW-1:0]    dropped_total_o;
  logic [LineW-1:0]    line_now_o;

  // Typed-in result travelling alongside the tick being offered
  logic    lit_on   = 1'b0;
  totals_t lit_want = '0;

  // Line model state and its copy of the registers
  logic [BusyW-1:0]      svc_ticks = ServiceTicksReset;
  logic [LimitW-1:0]     line_lim  = LineLimitReset;
  logic [StampWidth-1:0] tick_cnt  = '0;
  logic [StampWidth-1:0] stamps [QueueDepth];
  logic [PtrW-1:0]       head_ptr  = '0;
  logic [PtrW-1:0]       tail_ptr  = '0;
  logic [OccW-1:0]       occ       = '0;
  logic [BusyW-1:0]      busy_left = '0;
  logic [ServedW-1:0]    served_cnt = '0;
  logic [WaitW-1:0]      wait_sum  = '0;
  logic [LengthW-1:0]    len_sum   = '0;
  logic [DropW-1:0]      drop_cnt  = '0;

  totals_t pending_totals [$];
  int      n_errors    = 0;
  int      ticks_sent  = 0;
  int      writes_done = 0;
  int      burst_left  = 0;
  int      rx_left     = 0;
  int      idle_cycles = 0;

  bounded_queue_service_monitor_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .arrived_i       (arrived),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .served_total_o  (served_total_o),
    .wait_total_o    (wait_total_o),
    .length_total_o  (length_total_o),
    .dropped_total_o (dropped_total_o),
    .line_now_o      (line_now_o),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [63:0] sat_add(input logic [63:0] acc, input logic [63:0] inc,
                                          input logic [63:0] top);
    if (acc >= top || inc > top - acc) return top;
    return acc + inc;
  endfunction

  function automatic logic [PtrW-1:0] next_slot(input logic [PtrW-1:0] p);
    return (int'(p) == QueueDepth - 1) ? '0 : p + 1'b1;
  endfunction

  // Advance the line by one tick and return the totals it reports
  function automatic totals_t serve_tick(input logic arr);
    int                    cap;
    logic [StampWidth-1:0] waited_now;
    totals_t               t;
    cap = (int'(line_lim) > QueueDepth) ? QueueDepth : int'(line_lim);
    len_sum = LengthW'(sat_add(64'(len_sum), 64'(occ), Top48));
    if (arr) begin
      if (int'(occ) < cap) begin
        stamps[tail_ptr] = tick_cnt;
        tail_ptr = next_slot(tail_ptr);
        occ = occ + 1'b1;
      end else begin
        drop_cnt = DropW'(sat_add(64'(drop_cnt), 64'd1, Top32));
      end
    end
    if (busy_left != 0) busy_left = busy_left - 1'b1;
    if (busy_left == 0 && occ != 0) begin
      waited_now = tick_cnt - stamps[head_ptr];
      wait_sum   = WaitW'(sat_add(64'(wait_sum), 64'(waited_now), Top48));
      head_ptr   = next_slot(head_ptr);
      occ        = occ - 1'b1;
      busy_left  = svc_ticks;
      served_cnt = ServedW'(sat_add(64'(served_cnt), 64'd1, Top32));
    end
    tick_cnt = tick_cnt + 1'b1;
    t = '{served_cnt, wait_sum, len_sum, drop_cnt, LineW'(occ)};
    return t;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  // Record the expected totals of every accepted tick
  always @(posedge clk_i) begin : record_tick
    totals_t t;
    if (rst_ni && in_valid && in_ready_o) begin
      t = serve_tick(arrived);
      pending_totals.push_back(lit_on ? lit_want : t);
    end
  end

  // Compare every accepted result with the oldest expectation
  always @(posedge clk_i) begin : compare_result
    totals_t t;
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_totals.size() == 0) begin
        $error("result item arrived with no expectation waiting");
        n_errors++;
      end else begin
        t = pending_totals.pop_front();
        check_field("served_total", 64'(t.served), 64'(served_total_o));
        check_field("wait_total", 64'(t.waited), 64'(wait_total_o));
        check_field("length_total", 64'(t.length), 64'(length_total_o));
        check_field("dropped_total", 64'(t.dropped), 64'(dropped_total_o));
        check_field("line_now", 64'(t.line), 64'(line_now_o));
      end
    end
  end

  // Receiver: alternate ready runs and stalls of random length
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      out_ready <= !out_ready;
      rx_left   <= out_ready ? $urandom_range(0, 5) : $urandom_range(0, 30);
    end else begin
      rx_left <= rx_left - 1;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Offer one tick, opening a random gap at the end of each burst
  task automatic send_tick(input logic arr, input logic use_lit, input totals_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    arrived  <= arr;
    lit_on   <= use_lit;
    lit_want <= want;
    do @(posedge clk_i); while (!in_ready_o);
    ticks_sent++;
  endtask

  // Hold the sender until every result is in, then let the pipeline empty
  task automatic settle_line();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_totals.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    if (idx == CfgServiceTicks) svc_ticks = data[BusyW-1:0];
    else line_lim = data[LimitW-1:0];
    cfg_we <= 1'b0;
    @(posedge clk_i);
    writes_done++;
  endtask

  initial begin
    int                  svc_set [PhaseCount];
    int                  lim_set [PhaseCount];
    int                  rate;
    logic [CfgDataW-1:0] lim_word;

    // Assert reset with a real falling edge before the first clock edge
    rst_ni <= 1'b0;

    svc_set = '{1, 3, 0, 2, 6, 1, 0, 0, 0, 65535};
    lim_set = '{64, 64, 127, 16, 1, 0, 65, 0, 0, 64};
    // two settings drawn at random
    svc_set[7] = $urandom_range(0, 12);
    lim_set[7] = $urandom_range(0, 127);
    svc_set[8] = $urandom_range(0, 12);
    lim_set[8] = $urandom_range(0, 127);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    for (int i = 0; i < DirRows; i++) begin
      if (DirTable[i].is_cfg) begin
        settle_line();
        write_reg(DirTable[i].idx, DirTable[i].data);
      end else begin
        send_tick(DirTable[i].arrived, DirTable[i].lit, DirTable[i].want);
      end
    end

    // Random ticks, one arrival rate per register setting
    for (int p = 0; p < PhaseCount; p++) begin
      settle_line();
      write_reg(CfgServiceTicks, CfgDataW'(svc_set[p]));
      lim_word = CfgDataW'($urandom);
      lim_word[LimitW-1:0] = LimitW'(lim_set[p]);
      write_reg(CfgLineLimit, lim_word);
      rate = $urandom_range(15, 95);
      repeat (PhaseTicks) send_tick($urandom_range(0, 99) < rate, 1'b0, '0);
    end

    // Drain and report
    settle_line();
    repeat (4) @(posedge clk_i);
    $display("Summary: %0d ticks over %0d register writes, served %0d, dropped %0d.",
             ticks_sent, writes_done, served_cnt, drop_cnt);
    $display("Covered empty and full line, zero and slow service, limits 0 to 127.");
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/bqsm_pkg.sv
hw/rtl/bqsm_line.sv
hw/rtl/bounded_queue_service_monitor_unit.sv
hw/rtl/bqsm_checker.sv
verif/bounded_queue_service_monitor_unit_tb.sv
